### rtl/tiled_to_linear_pixel_mapper_core_defines.svh
// Assertion helpers, clocked on i_clk and held off during reset.
`ifndef TILED_TO_LINEAR_PIXEL_MAPPER_CORE_DEFINES_SVH
`define TILED_TO_LINEAR_PIXEL_MAPPER_CORE_DEFINES_SVH

// Condition that must hold at every edge.
`define TLPM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tlpm_pkg.sv
package tlpm_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int LIN_OFF_W       = 20;
    localparam int OFF_FULL_W      = 44;
    localparam int PROD_W          = 43;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int MID_DEPTH       = 2;
    localparam int MID_CNT_W       = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH       = 8;
    localparam int OUT_CNT_W       = $clog2(OUT_DEPTH + 1);

    localparam logic [2:0] REG_DEPTH_MODE       = 3'd0;
    localparam logic [2:0] REG_METATILES_ACROSS = 3'd1;
    localparam logic [2:0] REG_METATILE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_METATILE_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_INVERT           = 3'd4;

    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;

    typedef struct packed {
        logic [7:0] tile_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [LIN_OFF_W-1:0] linear_offset;
        logic [7:0]           pixel_byte;
        logic                 out_of_range;
        logic                 end_of_image;
    } t_out;

    typedef struct packed {
        logic [1:0] depth_mode;
        logic [8:0] metatiles_across;
        logic [5:0] metatile_width;
        logic [5:0] metatile_height;
        logic       invert;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  pixel_byte;
        logic        last_byte;
        logic [1:0]  shift;
        logic [2:0]  byte_in_row;
        logic [2:0]  row_in_tile;
        logic [4:0]  sub_tile_col;
        logic [4:0]  sub_tile_row;
        logic [7:0]  metatile_col;
        logic [15:0] metatile_row;
    } t_rec;

    typedef struct packed {
        logic       push;
        logic [2:0] inflight;
    } t_back_stat;

    function automatic logic [5:0] clamp_tiles(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0) begin
            r = 6'd1;
        end else if (v > 6'd32) begin
            r = 6'd32;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [8:0] clamp_across(input logic [8:0] v);
        logic [8:0] r;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if (v > 9'd256) begin
            r = 9'd256;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // log2 of bytes per tile row
    function automatic logic [1:0] depth_shift(input logic [1:0] mode);
        logic [1:0] r;
        case (mode)
            DEPTH_1BPP: begin
                r = 2'd0;
            end
            DEPTH_4BPP: begin
                r = 2'd2;
            end
            default: begin
                r = 2'd3;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/tlpm_fifo.sv
module tlpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/tlpm_front.sv
module tlpm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tlpm_pkg::t_cfg i_cfg,
    input  logic          i_push,
    input  tlpm_pkg::t_in i_item,
    input  logic          i_room,
    output logic          o_wr,
    output tlpm_pkg::t_rec o_rec
);
    import tlpm_pkg::*;

    logic [2:0]  r_bir, n_bir;
    logic [2:0]  r_rit, n_rit;
    logic [4:0]  r_stc, n_stc;
    logic [4:0]  r_str, n_str;
    logic [7:0]  r_mcol, n_mcol;
    logic [15:0] r_mrow, n_mrow;

    logic [1:0]  shift;
    logic [3:0]  bpr;
    logic [5:0]  mw, mh;
    logic [8:0]  ma;
    logic [3:0]  bir_inc;
    logic [3:0]  rit_inc;
    logic [5:0]  stc_inc, str_inc;
    logic [8:0]  mcol_inc;
    logic [7:0]  pix;
    logic [7:0]  b;

    assign shift = depth_shift(i_cfg.depth_mode);
    assign bpr   = 4'd1 << shift;
    assign mw    = clamp_tiles(i_cfg.metatile_width);
    assign mh    = clamp_tiles(i_cfg.metatile_height);
    assign ma    = clamp_across(i_cfg.metatiles_across);
    assign o_wr  = i_push && i_room;
    assign b     = i_item.tile_byte;

    always_comb begin
        case (i_cfg.depth_mode)
            DEPTH_1BPP: begin
                pix = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
            end
            DEPTH_4BPP: begin
                pix = {b[3:0], b[7:4]};
            end
            default: begin
                pix = b;
            end
        endcase
        if (i_cfg.invert) begin
            pix = ~pix;
        end
    end

    always_comb begin
        o_rec.pixel_byte   = pix;
        o_rec.last_byte    = i_item.last_byte;
        o_rec.shift        = shift;
        o_rec.byte_in_row  = r_bir;
        o_rec.row_in_tile  = r_rit;
        o_rec.sub_tile_col = r_stc;
        o_rec.sub_tile_row = r_str;
        o_rec.metatile_col = r_mcol;
        o_rec.metatile_row = r_mrow;
    end

    // Carry chain: wrap to 0 at or past limit; last_byte zeroes all.
    always_comb begin
        bir_inc  = {1'b0, r_bir} + 4'd1;
        rit_inc  = {1'b0, r_rit} + 4'd1;
        stc_inc  = {1'b0, r_stc} + 6'd1;
        str_inc  = {1'b0, r_str} + 6'd1;
        mcol_inc = {1'b0, r_mcol} + 9'd1;
        n_bir  = r_bir;
        n_rit  = r_rit;
        n_stc  = r_stc;
        n_str  = r_str;
        n_mcol = r_mcol;
        n_mrow = r_mrow;
        if (bir_inc >= bpr) begin
            n_bir = '0;
            n_rit = rit_inc[2:0];
            if (rit_inc[3]) begin
                if (stc_inc >= mw) begin
                    n_stc = '0;
                    if (str_inc >= mh) begin
                        n_str = '0;
                        if (mcol_inc >= ma) begin
                            n_mcol = '0;
                            n_mrow = r_mrow + 16'd1;
                        end else begin
                            n_mcol = mcol_inc[7:0];
                        end
                    end else begin
                        n_str = str_inc[4:0];
                    end
                end else begin
                    n_stc = stc_inc[4:0];
                end
            end
        end else begin
            n_bir = bir_inc[2:0];
        end
        if (i_item.last_byte) begin
            n_bir  = '0;
            n_rit  = '0;
            n_stc  = '0;
            n_str  = '0;
            n_mcol = '0;
            n_mrow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir  <= '0;
            r_rit  <= '0;
            r_stc  <= '0;
            r_str  <= '0;
            r_mcol <= '0;
            r_mrow <= '0;
        end else if (o_wr) begin
            r_bir  <= n_bir;
            r_rit  <= n_rit;
            r_stc  <= n_stc;
            r_str  <= n_str;
            r_mcol <= n_mcol;
            r_mrow <= n_mrow;
        end
    end

endmodule

### rtl/tlpm_back.sv
module tlpm_back #(
    parameter int OFFSET_BITS = tlpm_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlpm_pkg::t_cfg                i_cfg,
    input  tlpm_pkg::t_rec                i_rec,
    input  logic                          i_rec_valid,
    input  logic [tlpm_pkg::OUT_CNT_W-1:0] i_out_count,
    output logic                          o_rec_pop,
    output tlpm_pkg::t_out                o_result,
    output tlpm_pkg::t_back_stat          o_stat
);
    import tlpm_pkg::*;

    logic [5:0] mw, mh;
    logic [8:0] ma;

    // stage 1: products of counters and sizes
    logic        r_v1;
    logic [21:0] r1_a;
    logic [13:0] r1_b;
    logic [14:0] r1_p;
    logic [4:0]  r1_str, r1_stc;
    logic [2:0]  r1_rit, r1_bir;
    logic [1:0]  r1_shift;
    logic [7:0]  r1_pix;
    logic        r1_last;

    // stage 2: row, column and pitch
    logic        r_v2;
    logic [24:0] r2_y;
    logic [15:0] r2_x;
    logic [17:0] r2_pitch;
    logic [7:0]  r2_pix;
    logic        r2_last;

    // stage 3: row times pitch
    logic              r_v3;
    logic [PROD_W-1:0] r3_prod;
    logic [15:0]       r3_x;
    logic [7:0]        r3_pix;
    logic              r3_last;

    logic [21:0]           n2_row;
    logic [13:0]           n2_col;
    logic [OFF_FULL_W-1:0] offset;
    logic [3:0]            pending;

    assign mw = clamp_tiles(i_cfg.metatile_width);
    assign mh = clamp_tiles(i_cfg.metatile_height);
    assign ma = clamp_across(i_cfg.metatiles_across);

    // take a record only if the result queue can absorb everything in flight
    assign pending   = 4'(i_out_count) + 4'(r_v1) + 4'(r_v2) + 4'(r_v3);
    assign o_rec_pop = i_rec_valid && (pending < 4'(OUT_DEPTH));

    assign n2_row = r1_a + 22'(r1_str);
    assign n2_col = r1_b + 14'(r1_stc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_rec_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a     <= 22'(i_rec.metatile_row) * 22'(mh);
        r1_b     <= 14'(i_rec.metatile_col) * 14'(mw);
        r1_p     <= 15'(ma) * 15'(mw);
        r1_str   <= i_rec.sub_tile_row;
        r1_stc   <= i_rec.sub_tile_col;
        r1_rit   <= i_rec.row_in_tile;
        r1_bir   <= i_rec.byte_in_row;
        r1_shift <= i_rec.shift;
        r1_pix   <= i_rec.pixel_byte;
        r1_last  <= i_rec.last_byte;

        r2_y     <= {n2_row[21:0], r1_rit};
        r2_x     <= (16'(n2_col) << r1_shift) + 16'(r1_bir);
        r2_pitch <= 18'(r1_p) << r1_shift;
        r2_pix   <= r1_pix;
        r2_last  <= r1_last;

        r3_prod  <= PROD_W'(r2_y) * PROD_W'(r2_pitch);
        r3_x     <= r2_x;
        r3_pix   <= r2_pix;
        r3_last  <= r2_last;
    end

    assign offset = OFF_FULL_W'(r3_prod) + OFF_FULL_W'(r3_x);

    always_comb begin
        for (int i = 0; i < LIN_OFF_W; i++) begin
            o_result.linear_offset[i] = (i < OFFSET_BITS) ? offset[i] : 1'b0;
        end
        o_result.pixel_byte   = r3_pix;
        o_result.out_of_range = |offset[OFF_FULL_W-1:OFFSET_BITS];
        o_result.end_of_image = r3_last;
    end

    assign o_stat.push     = r_v3;
    assign o_stat.inflight = {r_v3, r_v2, r_v1};

endmodule

### rtl/tiled_to_linear_pixel_mapper_core.sv
// Tiled-to-linear pixel mapper. Bytes of an 8x8-tile stream go in through
// push/full; for each one a result (linear bitmap offset, converted pixel
// byte, out-of-range flag, end-of-image copy) comes out through empty/pop
// in the same order. The front end steps the position counters and converts
// the byte, the back end is a three-stage multiply pipeline; a two-entry
// queue sits between them and an eight-entry queue holds results. One byte
// is taken per clock when results are drained; a result is visible once
// its byte has passed the middle queue, the pipeline and the result queue.
// Program the APB registers only while no results are outstanding.
module tiled_to_linear_pixel_mapper_core #(
    parameter int OFFSET_BITS = tlpm_pkg::OFFSET_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  tlpm_pkg::t_in                i_item,
    output logic                         empty,
    input  logic                         pop,
    output tlpm_pkg::t_out               o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlpm_pkg::ADDR_W-1:0]  paddr,
    input  logic [tlpm_pkg::DATA_W-1:0]  pwdata,
    output logic [tlpm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tlpm_pkg::*;

    t_cfg                 r_cfg;
    t_rec                 front_rec, mid_rec;
    t_out                 back_result;
    t_back_stat           back_stat;
    logic                 front_wr;
    logic                 mid_full, mid_empty, mid_pop;
    logic [MID_CNT_W-1:0] mid_count;
    logic                 out_full;
    logic [OUT_CNT_W-1:0] out_count;
    logic [2:0]           reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign full    = mid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode       <= DEPTH_4BPP;
            r_cfg.metatiles_across <= 9'd1;
            r_cfg.metatile_width   <= 6'd1;
            r_cfg.metatile_height  <= 6'd1;
            r_cfg.invert           <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEPTH_MODE: begin
                    r_cfg.depth_mode <= pwdata[1:0];
                end
                REG_METATILES_ACROSS: begin
                    r_cfg.metatiles_across <= pwdata[8:0];
                end
                REG_METATILE_WIDTH: begin
                    r_cfg.metatile_width <= pwdata[5:0];
                end
                REG_METATILE_HEIGHT: begin
                    r_cfg.metatile_height <= pwdata[5:0];
                end
                REG_INVERT: begin
                    r_cfg.invert <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEPTH_MODE: begin
                prdata = DATA_W'(r_cfg.depth_mode);
            end
            REG_METATILES_ACROSS: begin
                prdata = DATA_W'(r_cfg.metatiles_across);
            end
            REG_METATILE_WIDTH: begin
                prdata = DATA_W'(r_cfg.metatile_width);
            end
            REG_METATILE_HEIGHT: begin
                prdata = DATA_W'(r_cfg.metatile_height);
            end
            REG_INVERT: begin
                prdata = DATA_W'(r_cfg.invert);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    tlpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (push),
        .i_item  (i_item),
        .i_room  (!mid_full),
        .o_wr    (front_wr),
        .o_rec   (front_rec)
    );

    tlpm_fifo #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_wr),
        .i_data  (front_rec),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rec),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    tlpm_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec       (mid_rec),
        .i_rec_valid (!mid_empty),
        .i_out_count (out_count),
        .o_rec_pop   (mid_pop),
        .o_result    (back_result),
        .o_stat      (back_stat)
    );

    tlpm_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_stat.push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );

`include "tiled_to_linear_pixel_mapper_core_defines.svh"

    `TLPM_ASSERT_ALWAYS(a_no_out_overflow, !(back_stat.push && out_full), "result queue overflow")
    `TLPM_ASSERT_ALWAYS(a_credit_bound, (4'(out_count) + 4'($countones(back_stat.inflight)) <= 4'(OUT_DEPTH)), "in-flight transactions exceed result space")
    `TLPM_ASSERT_NEXT(a_drain_empty, (pop && !empty && out_count == OUT_CNT_W'(1) && !back_stat.push), empty, "result queue not empty after last pop")
    `TLPM_ASSERT_ALWAYS(a_mid_bound, (mid_count <= MID_CNT_W'(MID_DEPTH)), "middle queue count out of range")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tlpm_pkg::*;

    localparam logic [1:0] DEPTH_8BPP   = 2'd2;
    localparam logic [1:0] DEPTH_UNUSED = 2'd3;
    localparam int         OFFSET_BITS  = OFFSET_BITS_DEF;

    class pixel_map_scoreboard;
        t_cfg        cfg;
        logic [2:0]  byte_in_row;
        logic [2:0]  row_in_tile;
        logic [4:0]  sub_tile_col;
        logic [4:0]  sub_tile_row;
        logic [7:0]  metatile_col;
        logic [15:0] metatile_row;
        t_out        expected_pixels[$];
        int          errors;
        int          checked;

        function void clear_position();
            byte_in_row  = '0;
            row_in_tile  = '0;
            sub_tile_col = '0;
            sub_tile_row = '0;
            metatile_col = '0;
            metatile_row = '0;
        endfunction

        function void reset();
            cfg.depth_mode       = DEPTH_4BPP;
            cfg.metatiles_across = 9'd1;
            cfg.metatile_width   = 6'd1;
            cfg.metatile_height  = 6'd1;
            cfg.invert           = 1'b0;
            clear_position();
            expected_pixels.delete();
            errors  = 0;
            checked = 0;
        endfunction

        function void write_cfg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_DEPTH_MODE: begin
                    cfg.depth_mode = value[1:0];
                end
                REG_METATILES_ACROSS: begin
                    cfg.metatiles_across = value[8:0];
                end
                REG_METATILE_WIDTH: begin
                    cfg.metatile_width = value[5:0];
                end
                REG_METATILE_HEIGHT: begin
                    cfg.metatile_height = value[5:0];
                end
                REG_INVERT: begin
                    cfg.invert = value[0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [31:0] read_cfg(logic [2:0] idx);
            logic [31:0] r;
            case (idx)
                REG_DEPTH_MODE: begin
                    r = 32'(cfg.depth_mode);
                end
                REG_METATILES_ACROSS: begin
                    r = 32'(cfg.metatiles_across);
                end
                REG_METATILE_WIDTH: begin
                    r = 32'(cfg.metatile_width);
                end
                REG_METATILE_HEIGHT: begin
                    r = 32'(cfg.metatile_height);
                end
                default: begin
                    r = 32'(cfg.invert);
                end
            endcase
            return r;
        endfunction

        function int unsigned limit_size(int unsigned v, int unsigned hi);
            if (v == 0) begin
                return 1;
            end
            return (v > hi) ? hi : v;
        endfunction

        function void note_tile_byte(t_in item);
            int unsigned bpr;
            int unsigned mw;
            int unsigned mh;
            int unsigned ma;
            logic [63:0] pitch;
            logic [63:0] y;
            logic [63:0] x;
            logic [63:0] offset;
            logic [63:0] lim;
            logic [7:0]  pix;
            t_out        r;
            int          i;

            if (cfg.depth_mode == DEPTH_1BPP) begin
                bpr = 1;
            end else if (cfg.depth_mode == DEPTH_4BPP) begin
                bpr = 4;
            end else begin
                bpr = 8;
            end
            mw = limit_size(cfg.metatile_width, 32);
            mh = limit_size(cfg.metatile_height, 32);
            ma = limit_size(cfg.metatiles_across, 256);

            pitch  = 64'(ma) * 64'(mw) * 64'(bpr);
            y      = (64'(metatile_row) * 64'(mh) + 64'(sub_tile_row)) * 64'd8
                     + 64'(row_in_tile);
            x      = (64'(metatile_col) * 64'(mw) + 64'(sub_tile_col)) * 64'(bpr)
                     + 64'(byte_in_row);
            offset = y * pitch + x;
            lim    = (64'd1 << OFFSET_BITS) - 64'd1;

            case (cfg.depth_mode)
                DEPTH_1BPP: begin
                    for (i = 0; i < 8; i++) begin
                        pix[i] = item.tile_byte[7 - i];
                    end
                end
                DEPTH_4BPP: begin
                    pix = {item.tile_byte[3:0], item.tile_byte[7:4]};
                end
                default: begin
                    pix = item.tile_byte;
                end
            endcase
            if (cfg.invert) begin
                pix = ~pix;
            end

            r.linear_offset = LIN_OFF_W'(offset & lim);
            r.pixel_byte    = pix;
            r.out_of_range  = (offset > lim);
            r.end_of_image  = item.last_byte;
            expected_pixels.push_back(r);

            // counters wrap as soon as they reach or pass the current limit
            byte_in_row = byte_in_row + 3'd1;
            if (byte_in_row == 0 || byte_in_row >= bpr) begin
                byte_in_row = '0;
                row_in_tile = row_in_tile + 3'd1;
                if (row_in_tile == 0) begin
                    sub_tile_col = sub_tile_col + 5'd1;
                    if (sub_tile_col == 0 || sub_tile_col >= mw) begin
                        sub_tile_col = '0;
                        sub_tile_row = sub_tile_row + 5'd1;
                        if (sub_tile_row == 0 || sub_tile_row >= mh) begin
                            sub_tile_row = '0;
                            metatile_col = metatile_col + 8'd1;
                            if (metatile_col == 0 || metatile_col >= ma) begin
                                metatile_col = '0;
                                metatile_row = metatile_row + 16'd1;
                            end
                        end
                    end
                end
            end
            if (item.last_byte) begin
                clear_position();
            end
        endfunction

        function void check_pixel(t_out got);
            t_out want;
            if (expected_pixels.size() == 0) begin
                $error("result with no transaction pending: offset %0h pixel %0h",
                       got.linear_offset, got.pixel_byte);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (got.linear_offset !== want.linear_offset) begin
                $error("linear_offset: expected %0h, got %0h", want.linear_offset,
                       got.linear_offset);
                errors++;
            end
            if (got.pixel_byte !== want.pixel_byte) begin
                $error("pixel_byte: expected %0h, got %0h", want.pixel_byte,
                       got.pixel_byte);
                errors++;
            end
            if (got.out_of_range !== want.out_of_range) begin
                $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                       got.out_of_range);
                errors++;
            end
            if (got.end_of_image !== want.end_of_image) begin
                $error("end_of_image: expected %0b, got %0b", want.end_of_image,
                       got.end_of_image);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 2000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    t_in               i_item;
    logic              empty;
    logic              pop;
    t_out              o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pixel_map_scoreboard sb;
    int                  idle_pct = 18;
    int                  stall_cycles = 0;
    int                  readback_errors = 0;
    int                  settings = 0;

    tiled_to_linear_pixel_mapper_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.note_tile_byte(i_item);
            end
            if (pop && !empty) begin
                sb.check_pixel(o_result);
            end
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= {value, last};
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_cfg(idx, value);
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.read_cfg(idx)) begin
            $error("register %0d readback: expected %0h, got %0h", idx, sb.read_cfg(idx),
                   prdata);
            readback_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [1:0] depth, input logic [8:0] across,
                                  input logic [5:0] mw, input logic [5:0] mh,
                                  input logic inv);
        push <= 1'b0;
        while (sb.expected_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        write_reg(REG_DEPTH_MODE, 32'(depth));
        write_reg(REG_METATILES_ACROSS, 32'(across));
        write_reg(REG_METATILE_WIDTH, 32'(mw));
        write_reg(REG_METATILE_HEIGHT, 32'(mh));
        write_reg(REG_INVERT, 32'(inv));
        settings++;
    endtask

    function automatic logic [5:0] pick_tiles();
        case ($urandom_range(9))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'($urandom_range(63, 33));
            3: return 6'($urandom_range(32, 1));
            default: return 6'($urandom_range(3, 1));
        endcase
    endfunction

    initial begin
        logic [8:0] across;
        int         len;
        int         sent;
        int         phase;
        int         k;

        sb = new();
        sb.reset();
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // settings out of reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        apply_settings(DEPTH_1BPP, 9'd1, 6'd1, 6'd1, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        apply_settings(DEPTH_8BPP, 9'd1, 6'd1, 6'd1, 1'b0);
        send_byte(8'hC3, 1'b0);
        apply_settings(DEPTH_UNUSED, 9'd1, 6'd1, 6'd1, 1'b0);
        send_byte(8'h3C, 1'b1);
        // zero sizes act as one
        apply_settings(DEPTH_1BPP, 9'd0, 6'd0, 6'd0, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        // oversized values clamp
        apply_settings(DEPTH_8BPP, 9'd511, 6'd63, 6'd63, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        apply_settings(DEPTH_4BPP, 9'd256, 6'd32, 6'd32, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h99, 1'b1);

        // random settings; position counters carry over unless a last byte clears them
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0: across = 9'd0;
                1: across = 9'd256;
                2: across = 9'($urandom_range(511, 257));
                3: across = 9'($urandom_range(256, 1));
                default: across = 9'($urandom_range(3, 1));
            endcase
            apply_settings(2'($urandom_range(3)), across, pick_tiles(), pick_tiles(),
                           1'($urandom_range(1)));
            idle_pct = (phase == 6) ? 0 : 18;
            len = (phase == 6) ? 300 : $urandom_range(120, 10);
            for (k = 0; k < len; k++) begin
                send_byte(8'($urandom), ($urandom_range(99) == 0) ||
                          (k == len - 1 && $urandom_range(2) == 0));
            end
            sent += len;
            phase++;
        end
        idle_pct = 18;
        push <= 1'b0;

        while (sb.expected_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Checked %0d pixel transactions over %0d register settings: all depths,",
                 sb.checked, settings);
        $display("size clamps and counters left past their limits.");
        if (sb.errors == 0 && readback_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
